// ===== design/hbt_pkg.sv =====
`timescale 1ns / 1ps
package hbt_pkg;

   // Filter word: signed Q8.32
   localparam int VAL_W     = 40;
   localparam int GAIN_W    = 16;
   localparam int DT_W      = 32;
   localparam int PROD_W    = VAL_W + GAIN_W + 1;
   localparam int FRAC_BITS = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [VAL_W-1:0] VAL_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 40'sh80_0000_0000;

   // Item kinds
   localparam logic ACT_EDGE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DT    = 2'd2;

   // Hall patterns (A B C) for sectors 0 to 5
   localparam logic [2:0] HALL_S0 = 3'b101;
   localparam logic [2:0] HALL_S1 = 3'b100;
   localparam logic [2:0] HALL_S2 = 3'b110;
   localparam logic [2:0] HALL_S3 = 3'b010;
   localparam logic [2:0] HALL_S4 = 3'b011;
   localparam logic [2:0] HALL_S5 = 3'b001;

   typedef struct packed {
      logic start;  // item accepted this cycle
      logic tick;   // accepted item is a filter tick
      logic take;   // output register can load a result
   } hbt_ctl_type;

   typedef struct packed {
      logic idle;   // ready for the next item
      logic done;   // result available for the output register
   } hbt_stat_type;

   // Clamp a wide signed value to the filter word range
   function automatic logic signed [VAL_W-1:0] sat40(input logic signed [63:0] x);
      logic signed [VAL_W-1:0] r;
      if (x > 64'(VAL_MAX)) begin
         r = VAL_MAX;
      end else if (x < 64'(VAL_MIN)) begin
         r = VAL_MIN;
      end else begin
         r = $signed(x[VAL_W-1:0]);
      end
      return r;
   endfunction

endpackage

// ===== design/hall_alpha_beta_rotor_tracker_unit.sv =====
`timescale 1ns / 1ps
// Hall edge item: straight to the done state. Tick item: steps ERR to POS, then done.
// Done is left once the output register can load; a new item is taken only in idle.
// The tick time is set by the ten steps of the sequencer around one shared 40x17 multiplier.
// An item is accepted while the previous result still waits in the output register.
// Reset (synchronous, active high) clears sector, outputs and rate, loads register defaults.
module hall_alpha_beta_rotor_tracker_unit
   import hbt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [2:0] hall_bits, [7:3] zero
   input  logic [0:0]           req_tuser,   // [0] action
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [127:0]         rsp_tdata,   // [2:0] sector, [42:3] position,
                                             // [82:43] velocity, [122:83] acceleration,
                                             // [127:123] zero
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DT_W-1:0]      csr_wdata
);

   typedef struct packed {
      logic       valid;
      logic [2:0] sector;
   } hall_dec_type;

   // Map a hall pattern to its sector; 000 and 111 are not valid
   function automatic hall_dec_type hall_decode(input logic [2:0] bits);
      hall_dec_type d;
      d.valid  = 1'b1;
      d.sector = 3'd0;
      case (bits)
         HALL_S0: d.sector = 3'd0;
         HALL_S1: d.sector = 3'd1;
         HALL_S2: d.sector = 3'd2;
         HALL_S3: d.sector = 3'd3;
         HALL_S4: d.sector = 3'd4;
         HALL_S5: d.sector = 3'd5;
         default: d.valid  = 1'b0;
      endcase
      return d;
   endfunction

   logic [GAIN_W-1:0] alpha_ff, alpha_in;
   logic [GAIN_W-1:0] beta_ff, beta_in;
   logic [DT_W-1:0]   dt_ff, dt_in;
   logic [2:0]        sector_ff, sector_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [127:0]      rsp_data_ff, rsp_data_in;

   hbt_ctl_type  ctl;
   hbt_stat_type stat;
   hall_dec_type hall_dec;
   logic         accept;
   logic         load;

   logic signed [VAL_W-1:0] position_w;
   logic signed [VAL_W-1:0] velocity_w;
   logic signed [VAL_W-1:0] accel_w;

   hbt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .sector_i   (sector_ff),
      .alpha_i    (alpha_ff),
      .beta_i     (beta_ff),
      .dt_i       (dt_ff),
      .position_o (position_w),
      .velocity_o (velocity_w),
      .accel_o    (accel_w)
   );

   // Take an item whenever the sequencer is idle; the output register decouples rsp side
   assign req_tready = stat.idle;
   assign accept     = req_tvalid & req_tready;
   assign hall_dec   = hall_decode(req_tdata[2:0]);

   assign ctl.start = accept;
   assign ctl.tick  = (req_tuser[0] == ACT_TICK);
   assign ctl.take  = ~rsp_valid_ff | rsp_tready;

   // Load a finished result once the output register is free or being drained
   assign load = stat.done & ctl.take;

   // Register writes; an index beyond the list is dropped
   always_comb begin
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      dt_in    = dt_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ALPHA: alpha_in = csr_wdata[GAIN_W-1:0];
            CSR_BETA:  beta_in  = csr_wdata[GAIN_W-1:0];
            CSR_DT:    dt_in    = csr_wdata;
            default:   ;
         endcase
      end
   end

   // Hall edges update the sector at accept; invalid patterns hold it
   always_comb begin
      sector_in = sector_ff;
      if (accept && (req_tuser[0] == ACT_EDGE) && hall_dec.valid) begin
         sector_in = hall_dec.sector;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, accel_w, velocity_w, position_w, sector_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= 16'd45875;
         beta_ff      <= 16'd655;
         dt_ff        <= 32'd429497;
         sector_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         dt_ff        <= dt_in;
         sector_ff    <= sector_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/hbt_mul.sv =====
`timescale 1ns / 1ps
module hbt_mul
   import hbt_pkg::*;
(
   input  logic                     clock,
   input  logic signed [VAL_W-1:0]  mul_x,
   input  logic        [GAIN_W-1:0] mul_g,
   output logic signed [PROD_W-1:0] mul_p
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // Signed word times unsigned 16-bit factor, registered
   assign prod_in = mul_x * $signed({1'b0, mul_g});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

// ===== design/hbt_core.sv =====
`timescale 1ns / 1ps
module hbt_core
   import hbt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  hbt_ctl_type              ctl,
   output hbt_stat_type             stat,
   input  logic        [2:0]        sector_i,
   input  logic        [GAIN_W-1:0] alpha_i,
   input  logic        [GAIN_W-1:0] beta_i,
   input  logic        [DT_W-1:0]   dt_i,
   output logic signed [VAL_W-1:0]  position_o,
   output logic signed [VAL_W-1:0]  velocity_o,
   output logic signed [VAL_W-1:0]  accel_o
);

   typedef enum logic [11:0] {
      ST_IDLE = 12'b0000_0000_0001,
      ST_ERR  = 12'b0000_0000_0010,
      ST_MB   = 12'b0000_0000_0100,
      ST_MA   = 12'b0000_0000_1000,
      ST_BLO  = 12'b0000_0001_0000,
      ST_BHI  = 12'b0000_0010_0000,
      ST_RATE = 12'b0000_0100_0000,
      ST_AU   = 12'b0000_1000_0000,
      ST_ALO  = 12'b0001_0000_0000,
      ST_AHI  = 12'b0010_0000_0000,
      ST_POS  = 12'b0100_0000_0000,
      ST_DONE = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic signed [VAL_W-1:0] pos_ff, pos_in;
   logic signed [VAL_W-1:0] rate_ff, rate_in;
   logic signed [VAL_W-1:0] vel_ff, vel_in;
   logic signed [VAL_W-1:0] accel_ff, accel_in;
   logic signed [VAL_W-1:0] err_ff, err_in;
   logic signed [VAL_W-1:0] bu_ff, bu_in;
   logic signed [VAL_W-1:0] au_ff, au_in;
   logic signed [VAL_W:0]   ga_ff, ga_in;
   logic signed [VAL_W:0]   acc_ff, acc_in;

   logic signed [VAL_W-1:0]  mul_x;
   logic        [GAIN_W-1:0] mul_g;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [VAL_W:0]    prod_shr;
   logic signed [63:0]       target_w;
   logic signed [63:0]       err_diff;
   logic signed [63:0]       dt_term;
   logic signed [63:0]       rate_sum;
   logic signed [63:0]       au_sum;
   logic signed [63:0]       pos_sum;

   hbt_mul u_mul (
      .clock (clock),
      .mul_x (mul_x),
      .mul_g (mul_g),
      .mul_p (mul_p)
   );

   // Floor of product / 2^16
   assign prod_shr = $signed(mul_p[PROD_W-1:GAIN_W]);
   assign target_w = $signed({61'd0, sector_i}) <<< FRAC_BITS;
   assign err_diff = target_w - 64'(pos_ff);
   // Floor of (high partial + floor(low partial / 2^16)) / 2^16
   assign dt_term  = (64'(mul_p) + 64'(acc_ff)) >>> GAIN_W;
   assign rate_sum = 64'(rate_ff) + dt_term;
   assign au_sum   = 64'(ga_ff) + 64'(rate_ff);
   assign pos_sum  = 64'(pos_ff) + dt_term;

   // Feed the shared multiplier
   always_comb begin
      mul_x = err_ff;
      mul_g = beta_i;
      case (state_ff)
         ST_MB: begin
            mul_x = err_ff;
            mul_g = beta_i;
         end
         ST_MA: begin
            mul_x = err_ff;
            mul_g = alpha_i;
         end
         ST_BLO: begin
            mul_x = bu_ff;
            mul_g = dt_i[GAIN_W-1:0];
         end
         ST_BHI: begin
            mul_x = bu_ff;
            mul_g = dt_i[DT_W-1:GAIN_W];
         end
         ST_ALO: begin
            mul_x = au_ff;
            mul_g = dt_i[GAIN_W-1:0];
         end
         ST_AHI: begin
            mul_x = au_ff;
            mul_g = dt_i[DT_W-1:GAIN_W];
         end
         default: begin
            mul_x = err_ff;
            mul_g = beta_i;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      rate_in  = rate_ff;
      vel_in   = vel_ff;
      accel_in = accel_ff;
      err_in   = err_ff;
      bu_in    = bu_ff;
      au_in    = au_ff;
      ga_in    = ga_ff;
      acc_in   = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in = ctl.tick ? ST_ERR : ST_DONE;
            end
         end
         ST_ERR: begin
            err_in   = sat40(err_diff);
            state_in = ST_MB;
         end
         ST_MB: begin
            state_in = ST_MA;
         end
         ST_MA: begin
            bu_in    = sat40(64'(prod_shr));
            state_in = ST_BLO;
         end
         ST_BLO: begin
            ga_in    = prod_shr;
            state_in = ST_BHI;
         end
         ST_BHI: begin
            acc_in   = prod_shr;
            state_in = ST_RATE;
         end
         ST_RATE: begin
            rate_in  = sat40(rate_sum);
            state_in = ST_AU;
         end
         ST_AU: begin
            au_in    = sat40(au_sum);
            state_in = ST_ALO;
         end
         ST_ALO: begin
            state_in = ST_AHI;
         end
         ST_AHI: begin
            acc_in   = prod_shr;
            state_in = ST_POS;
         end
         ST_POS: begin
            pos_in   = sat40(pos_sum);
            vel_in   = au_ff;
            accel_in = bu_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register has room
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         rate_ff  <= '0;
         vel_ff   <= '0;
         accel_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         rate_ff  <= rate_in;
         vel_ff   <= vel_in;
         accel_ff <= accel_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
      bu_ff  <= bu_in;
      au_ff  <= au_in;
      ga_ff  <= ga_in;
      acc_ff <= acc_in;
   end

   assign stat.idle  = (state_ff == ST_IDLE);
   assign stat.done  = (state_ff == ST_DONE);
   assign position_o = pos_ff;
   assign velocity_o = vel_ff;
   assign accel_o    = accel_ff;

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == ST_IDLE)
      else $error("item started while sequencer busy");

   a_tick_seq : assert property (@(posedge clock) disable iff (reset)
      (ctl.start && ctl.tick) |=> state_ff == ST_ERR)
      else $error("tick did not enter the filter sequence");

   a_done_take : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && ctl.take) |=> state_ff == ST_IDLE)
      else $error("result not released to output register");

   a_pos_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_POS) |=> $stable(pos_ff))
      else $error("position integrator moved outside its update step");

endmodule
